// ===== hdl/lorentz_boost_four_vector_unit_defines.svh =====
// Assertion macros for the Lorentz boost unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LORENTZ_BOOST_FOUR_VECTOR_UNIT_DEFINES_SVH
`define LORENTZ_BOOST_FOUR_VECTOR_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBFV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked after the antecedent, delayed by the dly argument.
`define LBFV_ASSERT_LATER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== hdl/lbfv_pkg.sv =====
// Shared widths, types and arithmetic helpers for the Lorentz boost unit.
// No dependencies.
package lbfv_pkg;

    localparam int W        = 32;   // Q16.16 word
    localparam int QF       = 16;   // fraction bits
    localparam int ONE_Q16  = 65536;
    localparam int PW       = 48;   // rounded product, signed
    localparam int SW       = 49;   // dot product sum, signed
    localparam int AW       = 49;   // u_i - v_i*u_t, signed
    localparam int KW       = 48;   // quotient magnitude after rounding
    localparam int QB       = 47;   // quotient bits, one per divider stage
    localparam int RW       = 32;   // divider remainder
    localparam int DW       = 32;   // divisor gamma + 1
    localparam int KTW      = 52;   // v_i*k term, signed
    localparam int TW       = 53;   // final sum before saturation
    localparam logic [63:0] TERM_LIM = 64'd1 << 50;

    localparam int FRONT_ST = 5;
    localparam int BACK_ST  = 3;
    localparam int LAT      = FRONT_ST + QB + 1 + BACK_ST;

    typedef struct packed {
        logic              flag;
        logic              zero;
        logic signed [W-1:0]  t;
        logic signed [AW-1:0] a_x;
        logic signed [AW-1:0] a_y;
        logic signed [AW-1:0] a_z;
        logic signed [W-1:0]  v_x;
        logic signed [W-1:0]  v_y;
        logic signed [W-1:0]  v_z;
    } side_t;

    typedef struct packed {
        logic [KW-1:0] ms;
        logic          neg;
        logic [DW-1:0] den;
    } dv_t;

    typedef struct packed {
        logic             ov;
        logic signed [W-1:0] val;
    } sat_t;

    function automatic logic [W-1:0] mag32(input logic signed [W-1:0] a);
        logic [W-1:0] n;
        n = -a;
        mag32 = a[W-1] ? n : a;
    endfunction

    // round to nearest, ties away from zero, then apply sign
    function automatic logic signed [PW-1:0] rnd_q16(input logic [63:0] p, input logic neg);
        logic [63:0] r;
        logic signed [PW-1:0] m;
        r = (p + 64'd32768) >> QF;
        m = $signed({1'b0, r[PW-2:0]});
        rnd_q16 = neg ? -m : m;
    endfunction

    function automatic sat_t sat32(input logic signed [TW-1:0] x);
        logic signed [TW-1:0] smax;
        logic signed [TW-1:0] smin;
        sat_t r;
        smax = TW'(2147483647);
        smin = ~smax;
        r.ov = 1'b0;
        r.val = x[W-1:0];
        if (x > smax)
        begin
            r.val = 32'h7fff_ffff;
            r.ov = 1'b1;
        end
        else if (x < smin)
        begin
            r.val = 32'h8000_0000;
            r.ov = 1'b1;
        end
        sat32 = r;
    endfunction

endpackage

// ===== hdl/lorentz_boost_four_vector_unit.sv =====
// Lorentz boost unit top level: boosts a Q16.16 four-vector by a given four-velocity.
// Depends on lbfv_pkg, lbfv_front, lbfv_div, lbfv_back and the defines header.
//
// Usage:
//   Drive the vector (vec_t..vec_z) and the boost (vel_gamma, vel_x..vel_z) and
//   raise start; the item is taken at any rising edge with start high, as busy
//   is always low. A new item may be started in every cycle.
//   Each item gives one result: done is high for exactly one cycle with
//   out_t..out_z and saturated valid, once the item has passed the front,
//   divider and back stages. Items leave in order. Throughput is one item per
//   cycle. The divider for s/(gamma+1) resolves one quotient bit per stage
//   over 47 stages; around it are five front stages for products and sums,
//   one rounding stage and three back stages for the k products and saturation.
//   Reset clears all valid bits at once; items in flight are dropped and no
//   done follows. The receiver cannot stall: results must be taken when done
//   is high.
`include "lorentz_boost_four_vector_unit_defines.svh"

module lorentz_boost_four_vector_unit
    import lbfv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [W-1:0] vec_t,
    input  logic signed [W-1:0] vec_x,
    input  logic signed [W-1:0] vec_y,
    input  logic signed [W-1:0] vec_z,
    input  logic [W-2:0]        vel_gamma,
    input  logic signed [W-1:0] vel_x,
    input  logic signed [W-1:0] vel_y,
    input  logic signed [W-1:0] vel_z,
    output logic                done,
    output logic signed [W-1:0] out_t,
    output logic signed [W-1:0] out_x,
    output logic signed [W-1:0] out_y,
    output logic signed [W-1:0] out_z,
    output logic                saturated
);

    logic          fr_vld;
    side_t         fr_side;
    dv_t           fr_dv;
    logic          dv_vld;
    logic [KW-1:0] dv_m;
    logic          dv_neg;
    side_t         dv_side;
    logic          clamp_in;

    // fully pipelined: never hold off an item
    assign busy = 1'b0;

    // accepted item whose gamma gets clamped
    assign clamp_in = start && !busy && vel_gamma < (W-1)'(ONE_Q16);

    lbfv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .vec_t     (vec_t),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .vel_gamma (vel_gamma),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .out_valid (fr_vld),
        .out_side  (fr_side),
        .out_dv    (fr_dv)
    );

    lbfv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_vld),
        .in_dv     (fr_dv),
        .in_side   (fr_side),
        .out_valid (dv_vld),
        .out_m     (dv_m),
        .out_neg   (dv_neg),
        .out_side  (dv_side)
    );

    lbfv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_vld),
        .in_m      (dv_m),
        .in_neg    (dv_neg),
        .in_side   (dv_side),
        .done      (done),
        .out_t     (out_t),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated)
    );

    `LBFV_ASSERT_LATER(a_item_out, start && !busy, LAT, done, "accepted item gave no result")
    `LBFV_ASSERT_NOW(a_no_ghost, done, $past(start && !busy, LAT), "result without an item")
    `LBFV_ASSERT_LATER(a_clamp_flag, clamp_in, LAT, done && saturated, "clamp not flagged")

endmodule

// ===== hdl/lbfv_front.sv =====
// Front pipeline: gamma clamp, products, dot product, time component.
// Depends on lbfv_pkg.
module lbfv_front
    import lbfv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  vec_t,
    input  logic signed [W-1:0]  vec_x,
    input  logic signed [W-1:0]  vec_y,
    input  logic signed [W-1:0]  vec_z,
    input  logic [W-2:0]         vel_gamma,
    input  logic signed [W-1:0]  vel_x,
    input  logic signed [W-1:0]  vel_y,
    input  logic signed [W-1:0]  vel_z,
    output logic                 out_valid,
    output side_t                out_side,
    output dv_t                  out_dv
);

    typedef struct packed {
        logic [W-2:0]        g;
        logic signed [W-1:0] u0;
        logic signed [W-1:0] u1;
        logic signed [W-1:0] u2;
        logic signed [W-1:0] u3;
        logic signed [W-1:0] v1;
        logic signed [W-1:0] v2;
        logic signed [W-1:0] v3;
    } item_t;

    // stage A: register the item, clamp gamma
    logic  a_vld_reg;
    item_t a_item_reg;
    logic  a_flag_reg;
    item_t a_item_next;
    logic  a_flag_next;

    always_comb
    begin
        a_flag_next = vel_gamma < (W-1)'(ONE_Q16);
        a_item_next.g  = a_flag_next ? (W-1)'(ONE_Q16) : vel_gamma;
        a_item_next.u0 = vec_t;
        a_item_next.u1 = vec_x;
        a_item_next.u2 = vec_y;
        a_item_next.u3 = vec_z;
        a_item_next.v1 = vel_x;
        a_item_next.v2 = vel_y;
        a_item_next.v3 = vel_z;
    end

    // stage B: magnitude products
    logic        b_vld_reg;
    item_t       b_item_reg;
    logic        b_flag_reg;
    logic [63:0] b_p_reg [7];
    logic [6:0]  b_n_reg;
    logic [63:0] b_p_next [7];
    logic [6:0]  b_n_next;
    logic [W-1:0] m_u0, m_u1, m_u2, m_u3, m_v1, m_v2, m_v3;

    always_comb
    begin
        m_u0 = mag32(a_item_reg.u0);
        m_u1 = mag32(a_item_reg.u1);
        m_u2 = mag32(a_item_reg.u2);
        m_u3 = mag32(a_item_reg.u3);
        m_v1 = mag32(a_item_reg.v1);
        m_v2 = mag32(a_item_reg.v2);
        m_v3 = mag32(a_item_reg.v3);
        b_p_next[0] = 64'(a_item_reg.g) * 64'(m_u0);
        b_p_next[1] = 64'(m_v1) * 64'(m_u1);
        b_p_next[2] = 64'(m_v2) * 64'(m_u2);
        b_p_next[3] = 64'(m_v3) * 64'(m_u3);
        b_p_next[4] = 64'(m_v1) * 64'(m_u0);
        b_p_next[5] = 64'(m_v2) * 64'(m_u0);
        b_p_next[6] = 64'(m_v3) * 64'(m_u0);
        b_n_next[0] = a_item_reg.u0[W-1];
        b_n_next[1] = a_item_reg.v1[W-1] ^ a_item_reg.u1[W-1];
        b_n_next[2] = a_item_reg.v2[W-1] ^ a_item_reg.u2[W-1];
        b_n_next[3] = a_item_reg.v3[W-1] ^ a_item_reg.u3[W-1];
        b_n_next[4] = a_item_reg.v1[W-1] ^ a_item_reg.u0[W-1];
        b_n_next[5] = a_item_reg.v2[W-1] ^ a_item_reg.u0[W-1];
        b_n_next[6] = a_item_reg.v3[W-1] ^ a_item_reg.u0[W-1];
    end

    // stage C: round back to Q16.16
    logic                 c_vld_reg;
    item_t                c_item_reg;
    logic                 c_flag_reg;
    logic signed [PW-1:0] c_w_reg [7];

    // stage D: dot product and spatial partial sums
    logic                 d_vld_reg;
    item_t                d_item_reg;
    logic                 d_flag_reg;
    logic signed [SW-1:0] d_s_reg;
    logic signed [PW-1:0] d_gu_reg;
    logic signed [AW-1:0] d_a_reg [3];
    logic signed [SW-1:0] d_s_next;
    logic signed [AW-1:0] d_a_next [3];

    always_comb
    begin
        d_s_next = $signed({c_w_reg[1][PW-1], c_w_reg[1]})
                 + $signed({c_w_reg[2][PW-1], c_w_reg[2]})
                 + $signed({c_w_reg[3][PW-1], c_w_reg[3]});
        d_a_next[0] = $signed({{(AW-W){c_item_reg.u1[W-1]}}, c_item_reg.u1})
                    - $signed({c_w_reg[4][PW-1], c_w_reg[4]});
        d_a_next[1] = $signed({{(AW-W){c_item_reg.u2[W-1]}}, c_item_reg.u2})
                    - $signed({c_w_reg[5][PW-1], c_w_reg[5]});
        d_a_next[2] = $signed({{(AW-W){c_item_reg.u3[W-1]}}, c_item_reg.u3})
                    - $signed({c_w_reg[6][PW-1], c_w_reg[6]});
    end

    // stage E: time component, divider operands
    logic                 e_vld_reg;
    side_t                e_side_reg;
    dv_t                  e_dv_reg;
    logic signed [TW-1:0] tp;
    sat_t                 t_sat;
    logic [SW-1:0]        s_neg;
    side_t                e_side_next;
    dv_t                  e_dv_next;

    always_comb
    begin
        tp = $signed({{(TW-PW){d_gu_reg[PW-1]}}, d_gu_reg})
           - $signed({{(TW-SW){d_s_reg[SW-1]}}, d_s_reg});
        t_sat = sat32(tp);
        s_neg = -d_s_reg;
        e_side_next.flag = d_flag_reg | t_sat.ov;
        e_side_next.zero = d_item_reg.g == (W-1)'(ONE_Q16);
        e_side_next.t    = t_sat.val;
        e_side_next.a_x  = d_a_reg[0];
        e_side_next.a_y  = d_a_reg[1];
        e_side_next.a_z  = d_a_reg[2];
        e_side_next.v_x  = d_item_reg.v1;
        e_side_next.v_y  = d_item_reg.v2;
        e_side_next.v_z  = d_item_reg.v3;
        e_dv_next.neg = d_s_reg[SW-1];
        e_dv_next.ms  = d_s_reg[SW-1] ? s_neg[KW-1:0] : d_s_reg[KW-1:0];
        e_dv_next.den = DW'({1'b0, d_item_reg.g}) + DW'(ONE_Q16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= a_item_next;
        a_flag_reg <= a_flag_next;
        b_item_reg <= a_item_reg;
        b_flag_reg <= a_flag_reg;
        b_p_reg    <= b_p_next;
        b_n_reg    <= b_n_next;
        c_item_reg <= b_item_reg;
        c_flag_reg <= b_flag_reg;
        for (int i = 0; i < 7; i++)
        begin
            c_w_reg[i] <= rnd_q16(b_p_reg[i], b_n_reg[i]);
        end
        d_item_reg <= c_item_reg;
        d_flag_reg <= c_flag_reg;
        d_s_reg    <= d_s_next;
        d_gu_reg   <= c_w_reg[0];
        d_a_reg    <= d_a_next;
        e_side_reg <= e_side_next;
        e_dv_reg   <= e_dv_next;
    end

    assign out_valid = e_vld_reg;
    assign out_side  = e_side_reg;
    assign out_dv    = e_dv_reg;

endmodule

// ===== hdl/lbfv_div.sv =====
// Pipelined restoring divider: round(|s| * 2^16 / (gamma + 1)), one quotient bit per stage.
// Depends on lbfv_pkg.
module lbfv_div
    import lbfv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  dv_t           in_dv,
    input  side_t         in_side,
    output logic          out_valid,
    output logic [KW-1:0] out_m,
    output logic          out_neg,
    output side_t         out_side
);

    localparam int RB0 = KW + QF - QB;   // dividend bits above the quotient

    logic          vld_reg  [1:QB];
    logic [RW-1:0] rem_reg  [1:QB];
    logic [QB-1:0] q_reg    [1:QB];
    logic [KW-1:0] ms_reg   [1:QB];
    logic [DW-1:0] den_reg  [1:QB];
    logic          neg_reg  [1:QB];
    side_t         side_reg [1:QB];

    genvar k;
    for (k = 0; k < QB; k++)
    begin : g_stage
        localparam int BI = QB - 1 - k;
        logic          vld_in;
        logic [RW-1:0] rem_in;
        logic [QB-1:0] q_in;
        logic [KW-1:0] ms_in;
        logic [DW-1:0] den_in;
        logic          neg_in;
        side_t         side_in;
        logic          nbit;
        logic [RW:0]   trial;
        logic [RW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = {{(RW-RB0){1'b0}}, in_dv.ms[KW-1:KW-RB0]};
            assign q_in    = '0;
            assign ms_in   = in_dv.ms;
            assign den_in  = in_dv.den;
            assign neg_in  = in_dv.neg;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k];
            assign rem_in  = rem_reg[k];
            assign q_in    = q_reg[k];
            assign ms_in   = ms_reg[k];
            assign den_in  = den_reg[k];
            assign neg_in  = neg_reg[k];
            assign side_in = side_reg[k];
        end

        // dividend is |s| shifted up by 16: its low 16 bits are zero
        if (BI >= QF)
        begin : g_bit
            assign nbit = ms_in[BI-QF];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_in, nbit};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
            q_reg[k+1]    <= {q_in[QB-2:0], ge};
            ms_reg[k+1]   <= ms_in;
            den_reg[k+1]  <= den_in;
            neg_reg[k+1]  <= neg_in;
            side_reg[k+1] <= side_in;
        end
    end

    // round half away from zero on the remainder
    logic          up;
    logic [KW-1:0] m_next;
    logic          o_vld_reg;
    logic [KW-1:0] o_m_reg;
    logic          o_neg_reg;
    side_t         o_side_reg;

    assign up     = {rem_reg[QB], 1'b0} >= {1'b0, den_reg[QB]};
    assign m_next = {1'b0, q_reg[QB]} + KW'(up);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else
        begin
            o_vld_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        o_m_reg    <= m_next;
        o_neg_reg  <= neg_reg[QB];
        o_side_reg <= side_reg[QB];
    end

    assign out_valid = o_vld_reg;
    assign out_m     = o_m_reg;
    assign out_neg   = o_neg_reg;
    assign out_side  = o_side_reg;

endmodule

// ===== hdl/lbfv_back.sv =====
// Back pipeline: v_i * k terms, final sums, saturation and result register.
// Depends on lbfv_pkg.
module lbfv_back
    import lbfv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [KW-1:0]       in_m,
    input  logic                in_neg,
    input  side_t               in_side,
    output logic                done,
    output logic signed [W-1:0] out_t,
    output logic signed [W-1:0] out_x,
    output logic signed [W-1:0] out_y,
    output logic signed [W-1:0] out_z,
    output logic                saturated
);

    // X1: partial products of |v_i| and |k|
    logic [KW-1:0]        km;
    logic signed [W-1:0]  vv [3];
    logic [W-1:0]         mv [3];
    logic [63:0]          ph_next [3];
    logic [PW-1:0]        pl_next [3];
    logic [2:0]           n_next;
    logic                 x1_vld_reg;
    side_t                x1_side_reg;
    logic [63:0]          x1_ph_reg [3];
    logic [PW-1:0]        x1_pl_reg [3];
    logic [2:0]           x1_n_reg;

    always_comb
    begin
        // k is zero when gamma is exactly one
        km = in_side.zero ? '0 : in_m;
        vv[0] = in_side.v_x;
        vv[1] = in_side.v_y;
        vv[2] = in_side.v_z;
        for (int i = 0; i < 3; i++)
        begin
            mv[i] = mag32(vv[i]);
            ph_next[i] = 64'(mv[i]) * 64'(km[KW-1:QF]);
            pl_next[i] = PW'(mv[i]) * PW'(km[QF-1:0]);
            n_next[i] = vv[i][W-1] ^ in_neg;
        end
    end

    // X2: combine, round, clamp, sign
    logic [63:0]           p [3];
    logic [63:0]           pc [3];
    logic signed [KTW-1:0] pm [3];
    logic signed [KTW-1:0] kt_next [3];
    logic                  x2_vld_reg;
    side_t                 x2_side_reg;
    logic signed [KTW-1:0] x2_kt_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p[i] = x1_ph_reg[i] + 64'((x1_pl_reg[i] + PW'(32768)) >> QF);
            pc[i] = (p[i] > TERM_LIM) ? TERM_LIM : p[i];
            pm[i] = $signed({1'b0, pc[i][KTW-2:0]});
            kt_next[i] = x1_n_reg[i] ? -pm[i] : pm[i];
        end
    end

    // X3: final sums and saturation
    logic signed [AW-1:0] aa [3];
    logic signed [TW-1:0] acc [3];
    sat_t                 sr [3];
    logic                 done_reg;
    logic signed [W-1:0]  t_reg;
    logic signed [W-1:0]  x_reg;
    logic signed [W-1:0]  y_reg;
    logic signed [W-1:0]  z_reg;
    logic                 sat_reg;
    logic                 sat_next;

    always_comb
    begin
        aa[0] = x2_side_reg.a_x;
        aa[1] = x2_side_reg.a_y;
        aa[2] = x2_side_reg.a_z;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = $signed({{(TW-AW){aa[i][AW-1]}}, aa[i]})
                   + $signed({{(TW-KTW){x2_kt_reg[i][KTW-1]}}, x2_kt_reg[i]});
            sr[i] = sat32(acc[i]);
        end
        sat_next = x2_side_reg.flag | sr[0].ov | sr[1].ov | sr[2].ov;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_vld_reg <= 1'b0;
            x2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            x1_vld_reg <= in_valid;
            x2_vld_reg <= x1_vld_reg;
            done_reg   <= x2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_side_reg <= in_side;
        x1_ph_reg   <= ph_next;
        x1_pl_reg   <= pl_next;
        x1_n_reg    <= n_next;
        x2_side_reg <= x1_side_reg;
        x2_kt_reg   <= kt_next;
        t_reg       <= x2_side_reg.t;
        x_reg       <= sr[0].val;
        y_reg       <= sr[1].val;
        z_reg       <= sr[2].val;
        sat_reg     <= sat_next;
    end

    assign done      = done_reg;
    assign out_t     = t_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign saturated = sat_reg;

endmodule

// ===== tb/lorentz_boost_four_vector_unit_test.sv =====
// Self-checking testbench for lorentz_boost_four_vector_unit: drives boost items,
// predicts each boosted vector and checks results in order.
// Depends on lbfv_pkg and the lorentz_boost_four_vector_unit RTL.
`timescale 1ns / 1ps

module lorentz_boost_four_vector_unit_test
    import lbfv_pkg::*;
();

    typedef struct {
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } boost_result_t;

    int unsigned n_errors;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    class boost_scoreboard;
        boost_result_t pending[$];
        int unsigned   n_checked;
        int unsigned   n_saturated;

        // round(a*b/2^16), ties away from zero, magnitude capped at 2^50
        function longint scaled_product(longint a, longint b);
            logic    neg;
            longint  ma;
            longint  mb;
            longint  p;
            neg = (a < 0) != (b < 0);
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            if (ma > 64'h8000_0000) ma = 64'h8000_0000;
            if (mb > 64'hFFFF_FFFF_FFFF) mb = 64'hFFFF_FFFF_FFFF;
            p = ma * (mb >>> 16) + ((ma * (mb & 16'hFFFF) + 32768) >>> 16);
            if (p > (64'sd1 <<< 50)) p = 64'sd1 <<< 50;
            return neg ? -p : p;
        endfunction

        function longint scaled_quotient(longint s, longint den);
            longint ms;
            longint q;
            longint r;
            longint m;
            ms = s < 0 ? -s : s;
            q = ms / den;
            r = ms % den;
            m = (q <<< 16) + (((r <<< 16) + (den >>> 1)) / den);
            if (m > (64'sd1 <<< 50)) m = 64'sd1 <<< 50;
            return s < 0 ? -m : m;
        endfunction

        function logic signed [31:0] clip(longint v, ref logic flag);
            if (v > 64'sd2147483647)
            begin
                flag = 1'b1;
                return 32'h7fff_ffff;
            end
            if (v < -64'sd2147483648)
            begin
                flag = 1'b1;
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        function void note_item(logic signed [31:0] ut, logic signed [31:0] ux,
                                logic signed [31:0] uy, logic signed [31:0] uz,
                                logic [30:0] gam, logic signed [31:0] vx,
                                logic signed [31:0] vy, logic signed [31:0] vz);
            boost_result_t r;
            longint g;
            longint s;
            longint k;
            longint ui[3];
            longint vi[3];
            longint o[3];
            logic flag;
            flag = 1'b0;
            g = gam;
            if (g < ONE_Q16)
            begin
                g = ONE_Q16;
                flag = 1'b1;
            end
            ui = '{ux, uy, uz};
            vi = '{vx, vy, vz};
            s = 0;
            for (int i = 0; i < 3; i++) s += scaled_product(vi[i], ui[i]);
            r.t = clip(scaled_product(g, ut) - s, flag);
            k = (g == ONE_Q16) ? 0 : scaled_quotient(s, g + ONE_Q16);
            for (int i = 0; i < 3; i++)
                o[i] = ui[i] - scaled_product(vi[i], ut) + scaled_product(vi[i], k);
            r.x = clip(o[0], flag);
            r.y = clip(o[1], flag);
            r.z = clip(o[2], flag);
            r.sat = flag;
            pending.push_back(r);
        endfunction

        task check_result(logic signed [31:0] t, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] z,
                          logic sat);
            boost_result_t w;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            n_checked++;
            if (w.sat) n_saturated++;
            if (t !== w.t) report_mismatch("out_t", t, w.t);
            if (x !== w.x) report_mismatch("out_x", x, w.x);
            if (y !== w.y) report_mismatch("out_y", y, w.y);
            if (z !== w.z) report_mismatch("out_z", z, w.z);
            if (sat !== w.sat) report_mismatch("saturated", sat, w.sat);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] vec_t, vec_x, vec_y, vec_z;
    logic [30:0] vel_gamma;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic done;
    logic signed [31:0] out_t, out_x, out_y, out_z;
    logic saturated;

    boost_scoreboard boosts;
    longint unsigned cycle_count;
    localparam longint unsigned CYCLE_LIMIT = 200000;

    lorentz_boost_four_vector_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vec_t(vec_t), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .vel_gamma(vel_gamma), .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .done(done), .out_t(out_t), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("lorentz_boost_four_vector_unit regression: fail");
            $finish;
        end
    end

    // note accepted items and check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            boosts.note_item(vec_t, vec_x, vec_y, vec_z, vel_gamma, vel_x, vel_y, vel_z);
        if (rst_n && done)
            boosts.check_result(out_t, out_x, out_y, out_z, saturated);
    end

    function automatic logic signed [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $signed(32'($urandom_range(0, 8)) << 16) * ($urandom_range(0, 1) ? 1 : -1);
            2: return $signed($urandom) >>> $urandom_range(0, 31);
            default: return $signed($urandom) >>> $urandom_range(8, 20);
        endcase
    endfunction

    // mostly gamma 1 to 21, small velocities not tied to gamma; else any values
    task automatic load_random();
        int sel;
        sel = $urandom_range(0, 9);
        vec_t <= any_word();
        vec_x <= any_word();
        vec_y <= any_word();
        vec_z <= any_word();
        if (sel < 7)
        begin
            vel_gamma <= 31'(ONE_Q16 + $urandom_range(0, 20 * ONE_Q16));
            vel_x <= $signed($urandom) >>> $urandom_range(10, 16);
            vel_y <= $signed($urandom) >>> $urandom_range(10, 16);
            vel_z <= $signed($urandom) >>> $urandom_range(10, 16);
        end
        else
        begin
            vel_gamma <= (sel == 7) ? 31'($urandom_range(0, ONE_Q16)) : 31'($urandom);
            vel_x <= any_word();
            vel_y <= any_word();
            vel_z <= any_word();
        end
    endtask

    // leave start high so directed items go back to back
    task automatic send_item(input logic signed [31:0] t, x, y, z, input logic [30:0] g,
                             input logic signed [31:0] vx, vy, vz);
        vec_t <= t; vec_x <= x; vec_y <= y; vec_z <= z;
        vel_gamma <= g; vel_x <= vx; vel_y <= vy; vel_z <= vz;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic send_random_bursts(input int total);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < total)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < total; i++)
            begin
                load_random();
                start <= 1'b1;
                do @(posedge clk); while (busy);
                @(negedge clk);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        start <= 1'b0;
    endtask

    initial
    begin
        boosts = new();
        n_errors = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        {vec_t, vec_x, vec_y, vec_z} = '0;
        vel_gamma = 31'(ONE_Q16);
        {vel_x, vel_y, vel_z} = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // rest frame, clamped gamma, gamma one with stray velocity, extremes
        send_item(32'h0001_0000, 32'h0002_0000, -32'sh0003_0000, 32'h0000_8000,
                  31'(ONE_Q16), 0, 0, 0);
        send_item(32'h0001_0000, 32'h0001_0000, 0, 0, 31'd0, 32'h0001_0000, 0, 0);
        send_item(32'h0001_0000, 32'h0001_0000, 0, 0, 31'(ONE_Q16 - 1), 0, 0, 0);
        send_item(32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  31'(ONE_Q16), 32'h0004_0000, -32'sh0002_0000, 32'h0001_0000);
        send_item(32'h0002_0000, 0, 0, 0, 31'h0002_0000, 32'h0001_bb68, 0, 0);
        send_item(32'h0002_0000, 32'h0001_0000, 0, 0, 31'h0002_0000, 0, 32'h0001_bb68, 0);
        send_item(32'h0002_0000, 0, 0, 32'h0001_0000, 31'h0002_0000, 0, 0, -32'sh0001_bb68);
        send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  31'(ONE_Q16 + 1), 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_item(0, 0, 0, 0, 31'h7fff_ffff, 0, 0, 0);
        send_item(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                  31'(ONE_Q16 + 1), 32'h0000_0001, 32'hffff_ffff, 32'h0000_8000);
        send_item(32'h0000_8000, 32'hffff_8000, 32'h0000_8000, 32'h0000_8000,
                  31'h0003_0000, 32'h0000_8000, 32'hffff_8000, 32'h0000_8000);

        send_random_bursts(1150);

        while (boosts.pending.size() != 0) @(negedge clk);
        repeat (LAT + 10) @(negedge clk);

        $display("checked %0d boosted vectors, %0d of them saturated or clamped",
                 boosts.n_checked, boosts.n_saturated);
        if (n_errors == 0)
            $display("lorentz_boost_four_vector_unit regression: pass");
        else
            $display("lorentz_boost_four_vector_unit regression: fail");
        $finish;
    end
endmodule
